### sv/entry_state_table_assert.svh
// Assertion macros shared by the entry state table modules
`ifndef ENTRY_STATE_TABLE_ASSERT_SVH
`define ENTRY_STATE_TABLE_ASSERT_SVH

// Check an expression at every clock edge outside reset
`define ETB_ASSERT_ALWAYS(lbl, expr) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (expr)) \
        else $error("entry_state_table: assertion failed");

// Check a consequent in the same cycle as its antecedent
`define ETB_ASSERT_IMPLY(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("entry_state_table: assertion failed");

// Check a consequent in the cycle after its antecedent
`define ETB_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("entry_state_table: assertion failed");

`endif

### sv/etb_pkg.sv
// Shared constants, codes, command types and helpers of the entry state table
`default_nettype none

package etb_pkg;

    localparam int CAPACITY = 64;
    localparam int ADDR_W   = $clog2(CAPACITY);
    localparam int SIZE_W   = $clog2(CAPACITY + 1);

    localparam int ACT_W    = 3;
    localparam int IDX_W    = 7;
    localparam int CODE_W   = 3;
    localparam int MASK_W   = 5;
    localparam int STS_W    = 2;
    localparam int CNT_W    = 7;
    localparam int POS_W    = 6;
    localparam int TSIZE_W  = 7;
    localparam int RES_W    = SIZE_W + 2;

    localparam int IN_DATA_W  = 24;
    localparam int OUT_DATA_W = 32;

    localparam logic [ACT_W-1:0] ACT_GET   = 3'd0;
    localparam logic [ACT_W-1:0] ACT_SET   = 3'd1;
    localparam logic [ACT_W-1:0] ACT_CSET  = 3'd2;
    localparam logic [ACT_W-1:0] ACT_COUNT = 3'd3;
    localparam logic [ACT_W-1:0] ACT_LIST  = 3'd4;

    localparam logic [CODE_W-1:0] ST_UNDEF = 3'd0;
    localparam logic [CODE_W-1:0] ST_INIT  = 3'd1;
    localparam logic [CODE_W-1:0] ST_DATA  = 3'd2;
    localparam logic [CODE_W-1:0] ST_LFAIL = 3'd3;
    localparam logic [CODE_W-1:0] ST_PFAIL = 3'd4;

    localparam logic [STS_W-1:0] STS_OK      = 2'd0;
    localparam logic [STS_W-1:0] STS_RANGE   = 2'd1;
    localparam logic [STS_W-1:0] STS_ILLEGAL = 2'd2;

    typedef struct packed {
        logic load;
        logic cnt_step;
        logic emit_one;
        logic emit_entry;
    } t_dp_cmd;

    typedef struct packed {
        logic out_free;
        logic cnt_done;
        logic list_last;
    } t_dp_status;

    function automatic logic transition_ok(input logic [CODE_W-1:0] from_code,
                                           input logic [CODE_W-1:0] to_code);
        logic [MASK_W-1:0] allowed;
        unique case (from_code)
            ST_UNDEF: allowed = 5'b10010;
            ST_INIT:  allowed = 5'b11110;
            ST_DATA:  allowed = 5'b11110;
            ST_LFAIL: allowed = 5'b01110;
            ST_PFAIL: allowed = 5'b10010;
            default:  allowed = 5'b00000;
        endcase
        return (to_code <= ST_PFAIL) && allowed[to_code];
    endfunction

    function automatic logic mask_hit(input logic [MASK_W-1:0] mask,
                                      input logic [CODE_W-1:0] code);
        return (code <= ST_PFAIL) && mask[code];
    endfunction

endpackage

`default_nettype wire

### sv/etb_datapath.sv
// Entry table memory, table size, scan counters and result register
`default_nettype none

module etb_datapath
    import etb_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire t_dp_cmd               i_cmd,
    output t_dp_status                 o_sts,
    input  wire logic [IN_DATA_W-1:0]  i_s_tdata,
    input  wire logic                  i_m_tready,
    output logic                       o_m_tvalid,
    output logic [OUT_DATA_W-1:0]      o_m_tdata,
    output logic                       o_m_tlast
);

`include "entry_state_table_assert.svh"

    logic [ACT_W-1:0]  in_act;
    logic [IDX_W-1:0]  in_idx;
    logic [CODE_W-1:0] in_tgt;
    logic [MASK_W-1:0] in_mask;

    logic [ACT_W-1:0]  r_act;
    logic [CODE_W-1:0] r_target;
    logic [MASK_W-1:0] r_mask;
    logic              r_res_ok;
    logic              r_idx_neg;
    logic [SIZE_W-1:0] r_pos,  n_pos;
    logic [SIZE_W-1:0] r_size, n_size;
    logic [CNT_W-1:0]  r_cnt;

    logic [CODE_W-1:0] mem [CAPACITY];
    logic [CAPACITY-1:0] r_valid;
    logic [CODE_W-1:0] r_rd_data;
    logic              r_rd_valid;

    logic                  r_out_valid;
    logic [OUT_DATA_W-1:0] r_out_data;
    logic                  r_out_last;

    logic [RES_W-1:0]  idx_ext;
    logic [RES_W-1:0]  res_sum;
    logic              res_ok;
    logic [SIZE_W-1:0] load_pos;
    logic [ADDR_W-1:0] rd_addr;
    logic [ADDR_W-1:0] wr_addr;
    logic              wr_en;

    logic [CODE_W-1:0] cur;
    logic              hit;
    logic              legal;
    logic              do_set;
    logic [SIZE_W-1:0] pos_p1;
    logic [SIZE_W-1:0] grow_size;
    logic              list_last;
    logic              out_free;

    logic [CODE_W-1:0]  res_state;
    logic [STS_W-1:0]   res_status;
    logic               res_written;
    logic [CNT_W-1:0]   res_count;
    logic               res_match;
    logic [POS_W-1:0]   res_pos;
    logic               res_last;
    logic [TSIZE_W-1:0] res_size;

    assign in_act  = i_s_tdata[2:0];
    assign in_idx  = i_s_tdata[9:3];
    assign in_tgt  = i_s_tdata[12:10];
    assign in_mask = i_s_tdata[17:13];

    assign idx_ext = {{(RES_W - IDX_W){in_idx[IDX_W-1]}}, in_idx};
    assign res_sum = in_idx[IDX_W-1] ? idx_ext + RES_W'(r_size) : idx_ext;
    assign res_ok  = !res_sum[RES_W-1] && (res_sum < RES_W'(CAPACITY));

    always_comb begin
        unique case (in_act) inside
            ACT_SET, ACT_CSET: load_pos = res_sum[SIZE_W-1:0];
            ACT_GET:           load_pos = SIZE_W'(in_idx[ADDR_W-1:0]);
            default:           load_pos = '0;
        endcase
    end

    assign cur       = r_rd_valid ? r_rd_data : ST_UNDEF;
    assign hit       = mask_hit(r_mask, cur);
    assign legal     = transition_ok(cur, r_target);
    assign do_set    = r_res_ok && ((r_act == ACT_SET) || ((r_act == ACT_CSET) && hit));
    assign pos_p1    = r_pos + SIZE_W'(1);
    assign grow_size = (pos_p1 > r_size) ? pos_p1 : r_size;
    assign list_last = (r_size == '0) || (pos_p1 == r_size);
    assign out_free  = !r_out_valid || i_m_tready;

    assign wr_en   = i_cmd.emit_one && do_set && legal;
    assign wr_addr = r_pos[ADDR_W-1:0];

    assign o_sts.out_free  = out_free;
    assign o_sts.cnt_done  = (r_pos >= r_size);
    assign o_sts.list_last = list_last;

    always_comb begin
        if (i_cmd.load) begin
            n_pos = load_pos;
        end else if (i_cmd.cnt_step || (i_cmd.emit_entry && !list_last)) begin
            n_pos = pos_p1;
        end else begin
            n_pos = r_pos;
        end
        rd_addr = n_pos[ADDR_W-1:0];
        n_size  = (i_cmd.emit_one && do_set) ? grow_size : r_size;
    end

    always_comb begin
        res_state   = ST_UNDEF;
        res_status  = STS_OK;
        res_written = 1'b0;
        res_count   = '0;
        res_match   = 1'b0;
        res_pos     = '0;
        res_last    = 1'b1;
        res_size    = TSIZE_W'(n_size);
        if (i_cmd.emit_entry) begin
            res_match = (r_size != '0) && hit;
            res_pos   = r_pos[POS_W-1:0];
            res_last  = list_last;
        end else begin
            case (r_act) inside
                ACT_GET: begin
                    res_state = r_idx_neg ? ST_UNDEF : cur;
                end
                ACT_SET, ACT_CSET: begin
                    if (!r_res_ok) begin
                        res_status = STS_RANGE;
                    end else begin
                        res_state = cur;
                        if (do_set) begin
                            if (legal) begin
                                res_written = 1'b1;
                            end else begin
                                res_status = STS_ILLEGAL;
                            end
                        end
                    end
                end
                ACT_COUNT: begin
                    res_count = r_cnt;
                end
                default: begin
                    res_state = ST_UNDEF;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= r_target;
        end
        r_rd_data  <= mem[rd_addr];
        r_rd_valid <= r_valid[rd_addr] || (wr_en && (wr_addr == rd_addr));
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_act     <= in_act;
            r_target  <= in_tgt;
            r_mask    <= in_mask;
            r_res_ok  <= res_ok;
            r_idx_neg <= in_idx[IDX_W-1];
        end
        if (i_cmd.load) begin
            r_cnt <= '0;
        end else if (i_cmd.cnt_step) begin
            r_cnt <= r_cnt + CNT_W'(hit);
        end
        if (i_cmd.emit_one || i_cmd.emit_entry) begin
            r_out_data <= {5'd0, res_size, res_pos, res_match, res_count,
                           res_written, res_status, res_state};
            r_out_last <= res_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid     <= '0;
            r_size      <= '0;
            r_pos       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (wr_en) begin
                r_valid[wr_addr] <= 1'b1;
            end
            r_size <= n_size;
            r_pos  <= n_pos;
            if (i_cmd.emit_one || i_cmd.emit_entry) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;
    assign o_m_tlast  = r_out_last;

    `ETB_ASSERT_ALWAYS(a_size_cap, r_size <= SIZE_W'(CAPACITY))
    `ETB_ASSERT_NEXT(a_size_grows, 1'b1, r_size >= $past(r_size))
    `ETB_ASSERT_IMPLY(a_wr_in_size, wr_en, SIZE_W'(wr_addr) < n_size)

endmodule

`default_nettype wire

### sv/etb_ctrl.sv
// Sequencer that steps the entry table datapath through each action
`default_nettype none

module etb_ctrl
    import etb_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_s_tvalid,
    output logic                  o_s_tready,
    input  wire logic [ACT_W-1:0] i_action,
    input  wire t_dp_status       i_sts,
    output t_dp_cmd               o_cmd
);

`include "entry_state_table_assert.svh"

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_COUNT,
        S_LIST
    } t_state;

    t_state r_state, n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_s_tvalid) begin
                    o_cmd.load = 1'b1;
                    case (i_action)
                        ACT_COUNT: n_state = S_COUNT;
                        ACT_LIST:  n_state = S_LIST;
                        default:   n_state = S_EXEC;
                    endcase
                end
            end
            S_EXEC: begin
                if (i_sts.out_free) begin
                    o_cmd.emit_one = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            S_COUNT: begin
                if (!i_sts.cnt_done) begin
                    o_cmd.cnt_step = 1'b1;
                end else if (i_sts.out_free) begin
                    o_cmd.emit_one = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            S_LIST: begin
                if (i_sts.out_free) begin
                    o_cmd.emit_entry = 1'b1;
                    if (i_sts.list_last) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_s_tready = (r_state == S_IDLE);

    `ETB_ASSERT_IMPLY(a_emit_free, o_cmd.emit_one || o_cmd.emit_entry, i_sts.out_free)
    `ETB_ASSERT_IMPLY(a_step_pending, o_cmd.cnt_step, !i_sts.cnt_done)
    `ETB_ASSERT_NEXT(a_load_leaves_idle, o_cmd.load, r_state != S_IDLE)

endmodule

`default_nettype wire

### sv/entry_state_table.sv
// Entry state table: per-entry status codes with get, set, count and list actions
//
// Input stream (s side) carries one action per transaction; output stream
// (m side) returns its results. One action is worked on at a time: s_tready
// is high only while the block is idle, and the finished result sits in an
// output register, so the next action is taken while it waits.
// Get, set and conditional set give one result: the action is registered and
// its entry read from the table memory, then the result is written to the
// output register once it is free. Count walks the used entries one per cycle
// through the table memory read port and answers when the walk is done. List
// gives one result per used entry (one result for an empty table), one per
// cycle while the receiver keeps m_tready high, tlast on the final one. All
// actions share the single read port of the table memory.
// Reset (synchronous, active low) empties the table: size zero, all entries
// undefined, output invalid. When the receiver stalls, the result holds on
// the output and the block waits; no result is dropped.
`default_nettype none

module entry_state_table
    import etb_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_s_tvalid,
    output logic                       o_s_tready,
    // action[2:0], entry_index[9:3], target_state[12:10], select_mask[17:13]
    input  wire logic [IN_DATA_W-1:0]  i_s_tdata,
    output logic                       o_m_tvalid,
    input  wire logic                  i_m_tready,
    // state_code[2:0], status[4:3], written[5], match_count[12:6],
    // match_bit[13], listed_position[19:14], table_size[26:20]
    output logic [OUT_DATA_W-1:0]      o_m_tdata,
    output logic                       o_m_tlast
);

    t_dp_cmd    cmd;
    t_dp_status sts;

    etb_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_action   (i_s_tdata[ACT_W-1:0]),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    etb_datapath u_datapath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .o_sts      (sts),
        .i_s_tdata  (i_s_tdata),
        .i_m_tready (i_m_tready),
        .o_m_tvalid (o_m_tvalid),
        .o_m_tdata  (o_m_tdata),
        .o_m_tlast  (o_m_tlast)
    );

endmodule

`default_nettype wire

### test/tb.sv
`timescale 1ns / 100ps
// Self-checking stream testbench for the entry state table: directed and random actions
module tb;
    import etb_pkg::*;

    localparam int STALL_LIMIT  = 3000;
    localparam int HOLD_AT      = 200;
    localparam int HOLD_CYCLES  = 400;
    localparam int TAIL_CYCLES  = 100;
    localparam int RANDOM_ITEMS = 225;
    localparam int MAX_REPORTS  = 10;

    localparam logic [ACT_W-1:0] ACT_RSVD_5 = 3'd5;
    localparam logic [ACT_W-1:0] ACT_RSVD_6 = 3'd6;
    localparam logic [ACT_W-1:0] ACT_RSVD_7 = 3'd7;

    localparam logic [CODE_W-1:0] ST_RSVD_7 = 3'd7;

    typedef struct packed {
        logic                     last;
        logic [OUT_DATA_W-28:0]   pad;
        logic [TSIZE_W-1:0]       size;
        logic [POS_W-1:0]         pos;
        logic                     match;
        logic [CNT_W-1:0]         count;
        logic                     written;
        logic [STS_W-1:0]         status;
        logic [CODE_W-1:0]        code;
    } t_outcome;

    typedef struct {
        logic [ACT_W-1:0]  act;
        logic [IDX_W-1:0]  idx;
        logic [CODE_W-1:0] tgt;
        logic [MASK_W-1:0] mask;
        bit                drain;
    } t_action;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic [IN_DATA_W-1:0]  s_tdata = '0;
    logic                  m_tready = 1'b0;
    wire                   s_tready;
    wire                   m_tvalid;
    wire [OUT_DATA_W-1:0]  m_tdata;
    wire                   m_tlast;

    t_action  pending_actions[$];
    t_outcome expected_results[$];
    logic [CODE_W-1:0] entry_code[CAPACITY];
    int tbl_size;
    int peak_size;
    int total_items = 1;
    int sent_cnt = 0;
    int outstanding = 0;
    int idle_run = 0;
    int hold_left = 0;
    bit hold_done = 1'b0;
    int err_cnt = 0;
    int n_checked = 0;
    int act_seen[8];
    int phase;
    int send_gap_pct;
    int recv_stall_pct;
    bit timed_out = 1'b0;

    entry_state_table dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_s_tdata  (s_tdata),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata),
        .o_m_tlast  (m_tlast)
    );

    initial begin
        forever #5 clk = ~clk;
    end

    always_comb begin
        phase = (sent_cnt * 3) / total_items;
        case (phase)
            0: begin
                send_gap_pct = 15;
                recv_stall_pct = 55;
            end
            1: begin
                send_gap_pct = 55;
                recv_stall_pct = 15;
            end
            default: begin
                send_gap_pct = 0;
                recv_stall_pct = 0;
            end
        endcase
    end

    function automatic logic [MASK_W-1:0] allowed_targets(input logic [CODE_W-1:0] from_code);
        case (from_code) inside
            ST_UNDEF:         return 5'b10010;
            ST_INIT, ST_DATA: return 5'b11110;
            ST_LFAIL:         return 5'b01110;
            ST_PFAIL:         return 5'b10010;
            default:          return 5'b00000;
        endcase
    endfunction

    function automatic bit mask_selects(input logic [MASK_W-1:0] mask,
                                        input logic [CODE_W-1:0] code);
        return (code <= ST_PFAIL) && mask[code];
    endfunction

    function automatic string show(input t_outcome r);
        return {$sformatf("code=%0d status=%0d written=%0d count=%0d match=%0d ",
                          r.code, r.status, r.written, r.count, r.match),
                $sformatf("pos=%0d last=%0d size=%0d pad=%0h",
                          r.pos, r.last, r.size, r.pad)};
    endfunction

    task automatic apply_action(input logic [IN_DATA_W-1:0] word);
        logic [ACT_W-1:0]  act;
        logic [CODE_W-1:0] tgt;
        logic [CODE_W-1:0] cur;
        logic [MASK_W-1:0] mask;
        logic [MASK_W-1:0] allowed;
        int idx;
        int pos;
        int n;
        t_outcome r;
        act  = word[2:0];
        idx  = $signed(word[9:3]);
        tgt  = word[12:10];
        mask = word[17:13];
        act_seen[act]++;
        r = '0;
        r.last = 1'b1;
        case (act)
            ACT_GET: begin
                r.code = (idx >= 0 && idx < tbl_size) ? entry_code[idx] : ST_UNDEF;
            end
            ACT_SET, ACT_CSET: begin
                pos = (idx < 0) ? idx + tbl_size : idx;
                if (pos < 0 || pos >= CAPACITY) begin
                    r.status = STS_RANGE;
                end else begin
                    cur = (pos < tbl_size) ? entry_code[pos] : ST_UNDEF;
                    if (act == ACT_SET || mask_selects(mask, cur)) begin
                        for (int i = tbl_size; i <= pos; i++)
                            entry_code[i] = ST_UNDEF;
                        if (pos >= tbl_size)
                            tbl_size = pos + 1;
                        cur = entry_code[pos];
                        r.code = cur;
                        allowed = allowed_targets(cur);
                        if (tgt <= ST_PFAIL && allowed[tgt]) begin
                            entry_code[pos] = tgt;
                            r.written = 1'b1;
                        end else begin
                            r.status = STS_ILLEGAL;
                        end
                    end else begin
                        r.code = cur;
                    end
                end
            end
            ACT_COUNT: begin
                n = 0;
                for (int i = 0; i < tbl_size; i++)
                    if (mask_selects(mask, entry_code[i]))
                        n++;
                r.count = CNT_W'(n);
            end
            default: ;
        endcase
        if (tbl_size > peak_size)
            peak_size = tbl_size;
        if (act == ACT_LIST && tbl_size != 0) begin
            for (int i = 0; i < tbl_size; i++) begin
                r = '0;
                r.match = mask_selects(mask, entry_code[i]);
                r.pos = POS_W'(i);
                r.last = (i == tbl_size - 1);
                r.size = TSIZE_W'(tbl_size);
                expected_results.push_back(r);
            end
        end else begin
            r.size = TSIZE_W'(tbl_size);
            expected_results.push_back(r);
        end
    endtask

    task automatic queue_action(input logic [ACT_W-1:0] act, input int idx,
                                input logic [CODE_W-1:0] tgt, input logic [MASK_W-1:0] mask,
                                input bit drain);
        t_action a;
        a.act = act;
        a.idx = IDX_W'(idx);
        a.tgt = tgt;
        a.mask = mask;
        a.drain = drain;
        pending_actions.push_back(a);
    endtask

    // sender
    always @(posedge clk) begin : driver
        t_action nxt;
        bit fired;
        bit free;
        if (!rst_n) begin
            s_tvalid <= 1'b0;
            s_tdata <= '0;
        end else begin
            fired = s_tvalid && s_tready;
            free = !s_tvalid || fired;
            if (fired)
                sent_cnt <= sent_cnt + 1;
            if (free) begin
                if (pending_actions.size() != 0 && $urandom_range(99) >= send_gap_pct
                    && (!pending_actions[0].drain || (!fired && outstanding == 0))) begin
                    nxt = pending_actions.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata <= IN_DATA_W'({nxt.mask, nxt.tgt, nxt.idx, nxt.act});
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // long receiver hold-off
    always @(posedge clk) begin
        if (!rst_n) begin
            hold_left <= 0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end else if (!hold_done && sent_cnt == HOLD_AT) begin
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end
    end

    // predict on input transactions, check output transactions
    always @(posedge clk) begin : monitor
        t_outcome got;
        t_outcome want;
        if (!rst_n) begin
            m_tready <= 1'b0;
            idle_run <= 0;
            outstanding <= 0;
            tbl_size = 0;
            peak_size = 0;
            for (int i = 0; i < CAPACITY; i++)
                entry_code[i] = ST_UNDEF;
        end else begin
            if (s_tvalid && s_tready)
                apply_action(s_tdata);
            if (m_tvalid && m_tready) begin
                got = {m_tlast, m_tdata};
                n_checked++;
                if (expected_results.size() == 0) begin
                    err_cnt++;
                    if (err_cnt <= MAX_REPORTS)
                        $display("ERROR: unexpected result at %0t: %s", $realtime, show(got));
                end else begin
                    want = expected_results.pop_front();
                    if (got !== want) begin
                        err_cnt++;
                        if (err_cnt <= MAX_REPORTS) begin
                            $display("ERROR: result %0d at %0t", n_checked, $realtime);
                            $display("  expected %s", show(want));
                            $display("  actual   %s", show(got));
                        end
                    end
                end
            end
            idle_run <= (s_tvalid && s_tready) ? 0 : idle_run + 1;
            outstanding <= expected_results.size();
            m_tready <= (hold_left == 0) && ($urandom_range(99) >= recv_stall_pct);
        end
    end

    initial begin
        int r;
        int idx;
        logic [ACT_W-1:0] act;
        logic [CODE_W-1:0] tgt;

        queue_action(ACT_LIST, 0, ST_UNDEF, 5'b11111, 1'b0);
        queue_action(ACT_COUNT, 0, ST_UNDEF, 5'b11111, 1'b0);
        queue_action(ACT_GET, 0, ST_UNDEF, 5'b00000, 1'b0);
        queue_action(ACT_GET, -64, ST_UNDEF, 5'b00000, 1'b0);
        queue_action(ACT_SET, -1, ST_INIT, 5'b00000, 1'b0);
        queue_action(ACT_CSET, 10, ST_INIT, 5'b00001, 1'b0);
        queue_action(ACT_CSET, 20, ST_INIT, 5'b11110, 1'b0);
        queue_action(ACT_CSET, -12, ST_INIT, 5'b11111, 1'b0);
        queue_action(ACT_SET, 3, ST_UNDEF, 5'b00000, 1'b0);
        queue_action(ACT_SET, 3, ST_RSVD_7, 5'b00000, 1'b0);
        queue_action(ACT_SET, 3, ST_PFAIL, 5'b00000, 1'b0);
        queue_action(ACT_SET, 3, ST_LFAIL, 5'b00000, 1'b0);
        queue_action(ACT_SET, 10, ST_DATA, 5'b00000, 1'b0);
        queue_action(ACT_SET, 10, ST_LFAIL, 5'b00000, 1'b0);
        queue_action(ACT_SET, -1, ST_DATA, 5'b00000, 1'b0);
        queue_action(ACT_SET, -11, ST_PFAIL, 5'b00000, 1'b0);
        queue_action(ACT_GET, 10, ST_UNDEF, 5'b00000, 1'b0);
        queue_action(ACT_GET, 63, ST_UNDEF, 5'b00000, 1'b0);
        queue_action(ACT_COUNT, 0, ST_UNDEF, 5'b00000, 1'b0);
        queue_action(ACT_LIST, 0, ST_UNDEF, 5'b10010, 1'b0);
        queue_action(ACT_RSVD_5, 63, ST_RSVD_7, 5'b11111, 1'b0);
        queue_action(ACT_RSVD_6, -64, ST_INIT, 5'b10101, 1'b0);
        queue_action(ACT_RSVD_7, 5, ST_DATA, 5'b01010, 1'b0);
        queue_action(ACT_SET, 63, ST_INIT, 5'b00000, 1'b1);
        queue_action(ACT_LIST, 0, ST_UNDEF, 5'b11111, 1'b0);

        for (int k = 0; k < RANDOM_ITEMS; k++) begin
            r = $urandom_range(99);
            if (r < 20)
                act = ACT_GET;
            else if (r < 55)
                act = ACT_SET;
            else if (r < 80)
                act = ACT_CSET;
            else if (r < 88)
                act = ACT_COUNT;
            else if (r < 95)
                act = ACT_LIST;
            else
                act = ACT_W'($urandom_range(7, 5));
            if ($urandom_range(99) < 70)
                idx = int'($urandom_range(31)) - 16;
            else
                idx = $signed(IDX_W'($urandom_range(127)));
            tgt = ($urandom_range(99) < 85) ? CODE_W'($urandom_range(4))
                                            : CODE_W'($urandom_range(7));
            queue_action(act, idx, tgt, MASK_W'($urandom_range(31)), k == 100 || k == 220);
        end
        total_items = pending_actions.size();

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        while (!timed_out && !(sent_cnt == total_items && outstanding == 0)) begin
            @(posedge clk);
            if (idle_run >= STALL_LIMIT)
                timed_out = 1'b1;
        end
        if (timed_out) begin
            $display("ERROR: no input transaction for %0d cycles, %0d of %0d actions sent",
                     STALL_LIMIT, sent_cnt, total_items);
        end else begin
            repeat (TAIL_CYCLES) @(posedge clk);
        end
        if (expected_results.size() != 0)
            $display("ERROR: %0d expected results never arrived", expected_results.size());

        $display("Drove %0d actions (get/set/cset/count/list/other: %0d/%0d/%0d/%0d/%0d/%0d)",
                 sent_cnt, act_seen[ACT_GET], act_seen[ACT_SET], act_seen[ACT_CSET],
                 act_seen[ACT_COUNT], act_seen[ACT_LIST],
                 act_seen[ACT_RSVD_5] + act_seen[ACT_RSVD_6] + act_seen[ACT_RSVD_7]);
        $display("Checked %0d results, table grew to %0d entries, %0d bad results",
                 n_checked, peak_size, err_cnt);
        if (err_cnt == 0 && !timed_out && expected_results.size() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
